// ===== rtl/core/mp2d_pkg.sv =====
// Package for the 2D max-pooling engine: widths, operation and status codes,
// configuration and geometry structs. No dependencies.
`default_nettype none
package mp2d_pkg;

  localparam int MapElements = 4096;
  localparam int OutElements = 4096;
  localparam int AddrBits    = $clog2(MapElements);
  localparam int SampleBits  = 16;
  localparam int GradBits    = 24;
  localparam int SrcBits     = AddrBits + 1;
  localparam int CountBits   = 21;

  localparam logic [GradBits-1:0] GradMax  = {1'b0, {(GradBits-1){1'b1}}};
  localparam logic [GradBits-1:0] GradMin  = {1'b1, {(GradBits-1){1'b0}}};
  localparam logic [SrcBits-1:0]  NoSource = '1;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_POOL  = 3'd1,
    OP_ROUTE = 3'd2,
    OP_READ  = 3'd3,
    OP_START = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_GEOM  = 2'd1,
    ST_RANGE = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_MAP_WIDTH     = 3'd0,
    REG_MAP_HEIGHT    = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_WINDOW_WIDTH  = 3'd3,
    REG_WINDOW_HEIGHT = 3'd4,
    REG_STEP          = 3'd5,
    REG_BORDER        = 3'd6
  } reg_t;

  typedef struct packed {
    logic [6:0] map_width;
    logic [6:0] map_height;
    logic [6:0] channel_count;
    logic [3:0] window_width;
    logic [3:0] window_height;
    logic [3:0] step;
    logic [2:0] border;
  } cfg_t;

  typedef struct packed {
    logic                 busy;
    logic                 ok;
    logic [6:0]           out_width;
    logic [AddrBits:0]    plane;
    logic [AddrBits:0]    in_plane;
    logic [CountBits-1:0] in_count;
    logic [CountBits-1:0] out_count;
  } geom_t;

endpackage
`default_nettype wire

// ===== rtl/core/mp2d_if.sv =====
// Item and result channel interfaces (valid/ready plus payload).
// Depends on mp2d_pkg.
`default_nettype none
interface mp2d_item_if;
  import mp2d_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   operation;
  logic [AddrBits-1:0]          element_index;
  logic signed [SampleBits-1:0] sample_value;
  modport source (output valid, operation, element_index, sample_value, input ready);
  modport sink (input valid, operation, element_index, sample_value, output ready);
endinterface

interface mp2d_result_if;
  import mp2d_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [GradBits-1:0] result_value;
  logic signed [SrcBits-1:0]  source_index;
  logic [1:0]                 status;
  modport source (output valid, result_value, source_index, status, input ready);
  modport sink (input valid, result_value, source_index, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mp2d_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module mp2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/mp2d_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on mp2d_pkg.
`default_nettype none
module mp2d_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [mp2d_pkg::AddrBits-1:0] dividend,
  input  wire logic [mp2d_pkg::AddrBits:0]   divisor,
  output logic                           done,
  output logic [mp2d_pkg::AddrBits-1:0]  quotient,
  output logic [mp2d_pkg::AddrBits:0]    remainder
);
  import mp2d_pkg::*;

  logic                        run;
  logic [$clog2(AddrBits)-1:0] cnt;
  logic [AddrBits:0]           dsr;
  logic [AddrBits:0]           trial;

  // shift in the next dividend bit
  assign trial = {remainder[AddrBits-1:0], quotient[AddrBits-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == '0);
      if (start) begin
        run       <= 1'b1;
        cnt       <= ($clog2(AddrBits))'(AddrBits - 1);
        remainder <= '0;
        quotient  <= dividend;
        dsr       <= divisor;
      end else if (run) begin
        if (trial >= dsr) begin
          remainder <= trial - dsr;
          quotient  <= {quotient[AddrBits-2:0], 1'b1};
        end else begin
          remainder <= trial;
          quotient  <= {quotient[AddrBits-2:0], 1'b0};
        end
        if (cnt == '0) begin
          run <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/mp2d_geom.sv =====
// Derives output size, plane sizes, element counts and the geometry flag
// from the configuration registers. Depends on mp2d_pkg and mp2d_div.
`default_nettype none
module mp2d_geom (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire mp2d_pkg::cfg_t cfg,
  output mp2d_pkg::geom_t    geom
);
  import mp2d_pkg::*;

  typedef enum logic [2:0] {G_IDLE, G_START, G_DX, G_DY, G_M1, G_M2, G_FIN} gstate_t;

  gstate_t              state;
  logic                 bad;
  logic                 ok;
  logic [7:0]           ph;
  logic [8:0]           ow, oh;
  logic [13:0]          inpl, opl;
  logic [CountBits-1:0] inc, outc;

  logic                  div_start, div_done;
  logic [AddrBits-1:0]   div_dividend, div_q;
  logic [AddrBits:0]     div_r;

  // padded map size
  logic [7:0] pw_c, ph_c;
  assign pw_c = {1'b0, cfg.map_width} + {4'b0, cfg.border, 1'b0};
  assign ph_c = {1'b0, cfg.map_height} + {4'b0, cfg.border, 1'b0};

  // divide (padded - window) by step, width then height
  assign div_start    = (state == G_START) || (state == G_DX && div_done);
  assign div_dividend = (state == G_START) ? AddrBits'(pw_c - {4'b0, cfg.window_width})
                                           : AddrBits'(ph - {4'b0, cfg.window_height});

  mp2d_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor({{(AddrBits-3){1'b0}}, cfg.step}), .done(div_done),
    .quotient(div_q), .remainder(div_r)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_START;
      ok    <= 1'b0;
    end else if (start) begin
      state <= G_START;
      ok    <= 1'b0;
    end else begin
      case (state)
        G_IDLE: ;
        G_START: begin
          ph    <= ph_c;
          bad   <= (cfg.map_width == '0) || (cfg.map_height == '0) ||
                   (cfg.channel_count == '0) || (cfg.window_width == '0) ||
                   (cfg.window_height == '0) || (cfg.step == '0) ||
                   (pw_c < {4'b0, cfg.window_width}) || (ph_c < {4'b0, cfg.window_height});
          state <= G_DX;
        end
        G_DX: begin
          if (div_done) begin
            bad   <= bad || (div_r != '0);
            ow    <= {1'b0, div_q[7:0]} + 9'd1;
            state <= G_DY;
          end
        end
        G_DY: begin
          if (div_done) begin
            bad   <= bad || (div_r != '0);
            oh    <= {1'b0, div_q[7:0]} + 9'd1;
            state <= G_M1;
          end
        end
        G_M1: begin
          bad   <= bad || (ow[8:7] != '0) || (oh[8:7] != '0);
          inpl  <= cfg.map_width * cfg.map_height;
          opl   <= ow[6:0] * oh[6:0];
          state <= G_M2;
        end
        G_M2: begin
          inc   <= CountBits'(inpl) * CountBits'(cfg.channel_count);
          outc  <= CountBits'(opl) * CountBits'(cfg.channel_count);
          state <= G_FIN;
        end
        G_FIN: begin
          ok    <= !bad && (inc <= CountBits'(MapElements)) &&
                   (outc <= CountBits'(OutElements));
          state <= G_IDLE;
        end
        default: state <= G_IDLE;
      endcase
    end
  end

  assign geom.busy      = (state != G_IDLE);
  assign geom.ok        = ok;
  assign geom.out_width = ow[6:0];
  assign geom.plane     = opl[AddrBits:0];
  assign geom.in_plane  = inpl[AddrBits:0];
  assign geom.in_count  = inc;
  assign geom.out_count = outc;

`ifndef ASSERT_OFF
  a_ok_only_idle: assert property (@(posedge clk) disable iff (rst)
    geom.ok |-> !geom.busy) else $error("geometry flag set while busy");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/mp2d_engine.sv =====
// Item sequencer: sample, argmax and gradient memories, window walk,
// gradient routing and clearing sweeps. Depends on mp2d_pkg, mp2d_if,
// mp2d_ram and mp2d_div.
`default_nettype none
module mp2d_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mp2d_pkg::cfg_t  cfg,
  input  wire mp2d_pkg::geom_t geom,
  mp2d_item_if.sink           item,
  mp2d_result_if.source       result
);
  import mp2d_pkg::*;

  typedef enum logic [3:0] {
    E_IDLE, E_CLEAR, E_RD, E_RT_A, E_RT_G, E_DIV1, E_DIV2, E_ORG,
    E_ROW, E_COL, E_DRAIN, E_PWR, E_EMIT
  } estate_t;

  estate_t state;

  // latched item and pending result
  logic signed [SampleBits-1:0] val_r;
  logic [AddrBits-1:0]          idx_r;
  logic [GradBits-1:0]          res_val;
  logic [SrcBits-1:0]           res_src;
  status_t                      res_st;

  // clearing sweep
  logic [AddrBits-1:0] clr_addr;
  logic                clr_all;

  // pooling walk; s_raddr_q is the address of the sample read in flight
  logic [6:0]                   c_r, yq_r, xr_r;
  logic [AddrBits-1:0]          cbase, rowaddr, where;
  logic [AddrBits-1:0]          s_raddr_q;
  logic signed [11:0]           y0, x0;
  logic [3:0]                   py, px;
  logic                         pend, found;
  logic signed [SampleBits-1:0] best;

  // memories
  logic                  s_we, a_we, g_we;
  logic [AddrBits-1:0]   s_raddr, a_waddr, a_raddr, g_waddr, g_raddr;
  logic [SampleBits-1:0] s_rdata;
  logic [SrcBits-1:0]    a_wdata, a_rdata;
  logic [GradBits-1:0]   g_wdata, g_rdata;

  // divider
  logic                div_start, div_done;
  logic [AddrBits-1:0] div_dividend, div_q;
  logic [AddrBits:0]   div_divisor, div_r;

  logic accept, in_rng, out_rng;
  assign item.ready = (state == E_IDLE) && !geom.busy;
  assign accept     = item.valid && item.ready;
  assign in_rng     = {{(CountBits-AddrBits){1'b0}}, item.element_index} < geom.in_count;
  assign out_rng    = {{(CountBits-AddrBits){1'b0}}, item.element_index} < geom.out_count;

  // window coordinates
  logic signed [11:0] y, x;
  logic               yin, xin;
  assign y   = y0 + $signed({8'b0, py});
  assign x   = x0 + $signed({8'b0, px});
  assign yin = !y[11] && (y[10:0] < {4'b0, cfg.map_height});
  assign xin = !x[11] && (x[10:0] < {4'b0, cfg.map_width});

  // route accumulation with saturation
  logic signed [GradBits:0] sum;
  logic                     sat;
  logic [GradBits-1:0]      sum_sat;
  assign sum     = $signed({g_rdata[GradBits-1], g_rdata}) +
                   $signed({{(GradBits+1-SampleBits){val_r[SampleBits-1]}}, val_r});
  assign sat     = sum[GradBits] != sum[GradBits-1];
  assign sum_sat = !sat ? sum[GradBits-1:0] : (sum[GradBits] ? GradMin : GradMax);

  // divider hookup: output index by plane, then remainder by output width
  assign div_start    = (accept && op_t'(item.operation) == OP_POOL && geom.ok && out_rng) ||
                        (state == E_DIV1 && div_done);
  assign div_dividend = (state == E_DIV1) ? div_r[AddrBits-1:0] : item.element_index;
  assign div_divisor  = (state == E_DIV1) ? {{(AddrBits-6){1'b0}}, geom.out_width} : geom.plane;

  mp2d_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  // memory port steering
  always_comb begin
    s_we    = accept && op_t'(item.operation) == OP_LOAD && geom.ok && in_rng;
    s_raddr = rowaddr + {{(AddrBits-7){1'b0}}, x[6:0]};
    a_we    = 1'b0;
    a_waddr = idx_r;
    a_wdata = found ? {1'b0, where} : NoSource;
    a_raddr = item.element_index;
    g_we    = 1'b0;
    g_waddr = where;
    g_wdata = sum_sat;
    g_raddr = (state == E_RT_A) ? a_rdata[AddrBits-1:0] : item.element_index;
    case (state)
      E_CLEAR: begin
        g_we    = 1'b1;
        g_waddr = clr_addr;
        g_wdata = '0;
        a_we    = clr_all;
        a_waddr = clr_addr;
        a_wdata = NoSource;
      end
      E_RT_G: g_we = 1'b1;
      E_PWR:  a_we = 1'b1;
      default: ;
    endcase
  end

  mp2d_ram #(.WIDTH(SampleBits), .DEPTH(MapElements)) u_sample (
    .clk(clk), .we(s_we), .waddr(item.element_index), .wdata(item.sample_value),
    .raddr(s_raddr), .rdata(s_rdata)
  );
  mp2d_ram #(.WIDTH(SrcBits), .DEPTH(OutElements)) u_argmax (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );
  mp2d_ram #(.WIDTH(GradBits), .DEPTH(MapElements)) u_grad (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= E_CLEAR;
      clr_all      <= 1'b1;
      clr_addr     <= '0;
      pend         <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      // compare the sample read last cycle
      if (pend && (!found || $signed(s_rdata) > best)) begin
        found <= 1'b1;
        best  <= $signed(s_rdata);
        where <= s_raddr_q;
      end
      pend <= 1'b0;
      case (state)
        E_IDLE: begin
          if (accept) begin
            idx_r   <= item.element_index;
            val_r   <= item.sample_value;
            res_val <= '0;
            res_src <= '0;
            res_st  <= ST_OK;
            found   <= 1'b0;
            case (op_t'(item.operation))
              OP_START: begin
                clr_all  <= 1'b0;
                clr_addr <= '0;
                res_st   <= geom.ok ? ST_OK : ST_GEOM;
                state    <= E_CLEAR;
              end
              OP_LOAD, OP_POOL, OP_ROUTE, OP_READ: begin
                if (!geom.ok) begin
                  res_st <= ST_GEOM;
                  state  <= E_EMIT;
                end else if (((op_t'(item.operation) == OP_LOAD ||
                               op_t'(item.operation) == OP_READ) && !in_rng) ||
                             ((op_t'(item.operation) == OP_POOL ||
                               op_t'(item.operation) == OP_ROUTE) && !out_rng)) begin
                  res_st <= ST_RANGE;
                  state  <= E_EMIT;
                end else begin
                  case (op_t'(item.operation))
                    OP_READ:  state <= E_RD;
                    OP_ROUTE: state <= E_RT_A;
                    OP_POOL:  state <= E_DIV1;
                    default:  state <= E_EMIT;
                  endcase
                end
              end
              default: state <= E_EMIT;
            endcase
          end
        end
        E_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= clr_all ? E_IDLE : E_EMIT;
          end
        end
        E_RD: begin
          res_val <= g_rdata;
          state   <= E_EMIT;
        end
        E_RT_A: begin
          if (a_rdata[SrcBits-1]) begin
            res_src <= NoSource;
            state   <= E_EMIT;
          end else begin
            where <= a_rdata[AddrBits-1:0];
            state <= E_RT_G;
          end
        end
        E_RT_G: begin
          res_val <= sum_sat;
          res_src <= {1'b0, where};
          res_st  <= sat ? ST_SAT : ST_OK;
          state   <= E_EMIT;
        end
        E_DIV1: begin
          if (div_done) begin
            c_r   <= div_q[6:0];
            state <= E_DIV2;
          end
        end
        E_DIV2: begin
          if (div_done) begin
            yq_r  <= div_q[6:0];
            xr_r  <= div_r[6:0];
            state <= E_ORG;
          end
        end
        E_ORG: begin
          cbase <= AddrBits'(c_r * geom.in_plane);
          y0    <= $signed({5'b0, yq_r} * {8'b0, cfg.step}) - $signed({9'b0, cfg.border});
          x0    <= $signed({5'b0, xr_r} * {8'b0, cfg.step}) - $signed({9'b0, cfg.border});
          py    <= '0;
          state <= E_ROW;
        end
        E_ROW: begin
          px <= '0;
          if (yin) begin
            rowaddr <= cbase + {5'b0, y[6:0]} * {5'b0, cfg.map_width};
            state   <= E_COL;
          end else if (py == cfg.window_height - 1'b1) begin
            state <= E_DRAIN;
          end else begin
            py <= py + 1'b1;
          end
        end
        E_COL: begin
          pend      <= xin;
          s_raddr_q <= s_raddr;
          if (px == cfg.window_width - 1'b1) begin
            if (py == cfg.window_height - 1'b1) begin
              state <= E_DRAIN;
            end else begin
              py    <= py + 1'b1;
              state <= E_ROW;
            end
          end else begin
            px <= px + 1'b1;
          end
        end
        E_DRAIN: state <= E_PWR;
        E_PWR: begin
          res_val <= found ? {{(GradBits-SampleBits){best[SampleBits-1]}}, best} : '0;
          res_src <= found ? {1'b0, where} : NoSource;
          state   <= E_EMIT;
        end
        E_EMIT: begin
          if (!result.valid || result.ready) begin
            result.valid        <= 1'b1;
            result.result_value <= res_val;
            result.source_index <= res_src;
            result.status       <= res_st;
            state               <= E_IDLE;
          end
        end
        default: state <= E_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_sat_clamped: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status == ST_SAT |->
      result.result_value == GradMax || result.result_value == GradMin)
    else $error("saturated gradient not at a limit");
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status == ST_GEOM || result.status == ST_RANGE) |->
      result.result_value == '0 && result.source_index == '0)
    else $error("rejected item carries data");
  a_nosrc_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.source_index == NoSource |-> result.result_value == '0)
    else $error("empty window or missing argmax with nonzero value");
  a_div_chain: assert property (@(posedge clk) disable iff (rst)
    state == E_DIV1 && div_done |=> state == E_DIV2)
    else $error("pool divide sequence broken");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/maxpool2d_forward_backward.sv =====
// 2D max pooling with argmax-routed gradient accumulation.
// Items arrive on the item channel (valid/ready transfer): operation, element
// index and a 16-bit sample. Each item yields one result transfer on the
// result channel: 24-bit value, 13-bit source index and 2-bit status.
// Geometry registers sit on the APB port; any write re-derives the output
// size, and no item is taken until that is done.
// Per item: load, rejected items and unknown codes go straight to the result;
// read fetches the gradient; route reads the argmax, then adds into the
// gradient, or stops when the output has no argmax; pool runs two index
// divides and one sample-memory read per window cell of the rows inside the
// map; start backward clears the gradient memory at one entry a cycle.
// After reset the argmax and gradient memories are swept, no item is taken
// meanwhile, and the geometry is derived from the reset configuration. The
// result sits in an output register: the next item is taken while it waits,
// and the block stalls only when a second result is ready before the
// receiver takes the first.
// Depends on mp2d_pkg, mp2d_if, mp2d_geom and mp2d_engine.
`default_nettype none
module maxpool2d_forward_backward (
  input  wire logic        clk,
  input  wire logic        rst,
  mp2d_item_if.sink        item,
  mp2d_result_if.source    result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mp2d_pkg::*;

  cfg_t  cfg;
  geom_t geom;
  logic  wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_width     <= 7'd8;
      cfg.map_height    <= 7'd8;
      cfg.channel_count <= 7'd1;
      cfg.window_width  <= 4'd2;
      cfg.window_height <= 4'd2;
      cfg.step          <= 4'd2;
      cfg.border        <= 3'd0;
    end else if (wr) begin
      case (reg_t'(paddr[4:2]))
        REG_MAP_WIDTH:     cfg.map_width     <= pwdata[6:0];
        REG_MAP_HEIGHT:    cfg.map_height    <= pwdata[6:0];
        REG_CHANNEL_COUNT: cfg.channel_count <= pwdata[6:0];
        REG_WINDOW_WIDTH:  cfg.window_width  <= pwdata[3:0];
        REG_WINDOW_HEIGHT: cfg.window_height <= pwdata[3:0];
        REG_STEP:          cfg.step          <= pwdata[3:0];
        REG_BORDER:        cfg.border        <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_t'(paddr[4:2]))
      REG_MAP_WIDTH:     prdata = {25'b0, cfg.map_width};
      REG_MAP_HEIGHT:    prdata = {25'b0, cfg.map_height};
      REG_CHANNEL_COUNT: prdata = {25'b0, cfg.channel_count};
      REG_WINDOW_WIDTH:  prdata = {28'b0, cfg.window_width};
      REG_WINDOW_HEIGHT: prdata = {28'b0, cfg.window_height};
      REG_STEP:          prdata = {28'b0, cfg.step};
      REG_BORDER:        prdata = {29'b0, cfg.border};
      default:           prdata = '0;
    endcase
  end

  mp2d_geom u_geom (
    .clk(clk), .rst(rst), .start(wr), .cfg(cfg), .geom(geom)
  );

  mp2d_engine u_engine (
    .clk(clk), .rst(rst), .cfg(cfg), .geom(geom), .item(item), .result(result)
  );
endmodule
`default_nettype wire
